/* rtl/psrl_pkg.sv */
// ----------------------------------------------------------------------------
// Per-source rate limiter package
// Shared widths, codes and structures for the rate limiter modules.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W      = 32;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int SLOT_W      = 4;
  localparam int MAXREQ_W    = 8;
  localparam int WIN_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0]    COUNT_MAX       = '1;
  localparam logic [MAXREQ_W-1:0]   MAX_REQ_RESET   = 8'd10;
  localparam logic [WIN_W-1:0]      WINDOW_RESET    = 16'd60;
  localparam logic [CNT_W-1:0]      TABLE_FULL      = CNT_W'(TABLE_ENTRIES);

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REQUESTS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SECONDS = 2'd1;

  typedef enum logic [1:0] {
    VERDICT_KNOWN   = 2'd0,
    VERDICT_NEW     = 2'd1,
    VERDICT_LIMITED = 2'd2,
    VERDICT_FULL    = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_UPDATE,
    ST_MISS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  window_start;
    logic               limited;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } tbl_rd_t;

  typedef struct packed {
    logic [MAXREQ_W-1:0] max_requests;
    logic [WIN_W-1:0]    window_seconds;
  } cfg_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

/* rtl/per_source_rate_limiter.sv */
// ----------------------------------------------------------------------------
// Per-source rate limiter
// Fixed-window request limiter over a table of source addresses.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  s_*       in         s_tvalid/s_tready  source_address, now_seconds
//  m_*       out        m_tvalid/m_tready  entry_slot, hit_count; verdict
//  cfg_*     in         cfg_valid/cfg_ready register index and data
//
//  A hit is found by the scan, then passes ST_HIT and ST_UPDATE; a miss scans
//  every entry in use, then passes ST_MISS; both results wait in ST_EMIT; the
//  table is compared one entry per cycle through its single read port.
//  Reset (synchronous, rst high) empties the table and restores the defaults.
//  The next request is taken in the cycle after the current result has moved into
//  the output register; m_tready low holds that result and then blocks s_tready.
// ----------------------------------------------------------------------------
module per_source_rate_limiter
  import psrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [63:0]            s_tdata,   // source_address[31:0], now_seconds[63:32]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // entry_slot[3:0], hit_count[11:4]
  output logic [1:0]             m_tuser,   // verdict[1:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t out_q;
  logic    res_valid;
  logic    res_ready;
  tbl_wr_t tbl_wr;
  tbl_rd_t tbl_rd;
  entry_t  tbl_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_requests   <= MAX_REQ_RESET;
      cfg.window_seconds <= WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_REQUESTS:   cfg.max_requests   <= cfg_data[MAXREQ_W-1:0];
        REG_WINDOW_SECONDS: cfg.window_seconds <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psrl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_address (s_tdata[31:0]),
    .in_now     (s_tdata[63:32]),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .tbl_wr     (tbl_wr),
    .tbl_rd     (tbl_rd),
    .tbl_data   (tbl_data)
  );

  psrl_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_data)
  );

  // Output register: a finished result waits here for the downstream side.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {4'b0, out_q.count, out_q.slot};
  assign m_tuser = out_q.verdict;

endmodule

/* rtl/psrl_table.sv */
// ----------------------------------------------------------------------------
// Source table
// One-write, one-read memory of source entries with a registered read port.
// ----------------------------------------------------------------------------
module psrl_table
  import psrl_pkg::*;
(
  input  logic    clk,
  input  tbl_wr_t wr,
  input  tbl_rd_t rd,
  output entry_t  rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.idx];
    end
  end

endmodule

/* rtl/psrl_ctrl.sv */
// ----------------------------------------------------------------------------
// Rate limiter sequencer
// Scans the table one entry per cycle, then updates or fills one entry unless the table is full.
// ----------------------------------------------------------------------------
module psrl_ctrl
  import psrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [TIME_W-1:0] in_now,
  input  cfg_t              cfg,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output tbl_wr_t           tbl_wr,
  output tbl_rd_t           tbl_rd,
  input  entry_t            tbl_data
);

  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  key;
  logic [TIME_W-1:0]  now;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   scan_idx;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic [IDX_W-1:0]   hit_idx;
  logic               expired;
  result_t            res_next;

  logic               more;
  logic               match;
  logic               issue;
  logic [TIME_W-1:0]  elapsed;
  logic [COUNT_W-1:0] cnt0;
  logic [COUNT_W-1:0] cnt1;
  logic               lim0;
  logic [TIME_W-1:0]  start0;
  logic               over;

  assign more  = (scan_idx < used);
  assign match = pend && (tbl_data.address == key);
  assign issue = (state == ST_SCAN) && more && !match;

  assign elapsed = now - tbl_data.window_start;

  // Entry values after a possible window restart.
  assign cnt0   = expired ? '0 : tbl_data.count;
  assign lim0   = expired ? 1'b0 : tbl_data.limited;
  assign start0 = expired ? now : tbl_data.window_start;
  assign cnt1   = (cnt0 == COUNT_MAX) ? cnt0 : COUNT_W'(cnt0 + 1'b1);
  assign over   = (cnt1 > COUNT_W'(cfg.max_requests));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_HIT;
        end else if (!pend && !more) begin
          state_next = ST_MISS;
        end
      end
      ST_HIT:    state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_EMIT;
      ST_MISS:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_IDLE);
    res_valid    = (state == ST_EMIT);
    tbl_rd.en    = issue;
    tbl_rd.idx   = scan_idx[IDX_W-1:0];
    tbl_wr       = '0;
    res_next     = res;
    case (state)
      ST_UPDATE: begin
        tbl_wr.en                 = 1'b1;
        tbl_wr.idx                = hit_idx;
        tbl_wr.entry.address      = key;
        tbl_wr.entry.window_start = start0;
        res_next.slot             = SLOT_W'(hit_idx);
        if (lim0) begin
          tbl_wr.entry.count   = cnt0;
          tbl_wr.entry.limited = 1'b1;
          res_next.verdict     = VERDICT_LIMITED;
          res_next.count       = cnt0;
        end else begin
          tbl_wr.entry.count   = cnt1;
          tbl_wr.entry.limited = over;
          res_next.verdict     = over ? VERDICT_LIMITED : VERDICT_KNOWN;
          res_next.count       = cnt1;
        end
      end
      ST_MISS: begin
        if (used == TABLE_FULL) begin
          res_next.verdict = VERDICT_FULL;
          res_next.slot    = '0;
          res_next.count   = '0;
        end else begin
          tbl_wr.en                 = 1'b1;
          tbl_wr.idx                = used[IDX_W-1:0];
          tbl_wr.entry.address      = key;
          tbl_wr.entry.count        = COUNT_W'(1);
          tbl_wr.entry.window_start = now;
          tbl_wr.entry.limited      = 1'b0;
          res_next.verdict          = VERDICT_NEW;
          res_next.slot             = SLOT_W'(used);
          res_next.count            = COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == ST_MISS && used != TABLE_FULL) begin
        used <= CNT_W'(used + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= scan_idx[IDX_W-1:0];
    if (state == ST_IDLE) begin
      key      <= in_address;
      now      <= in_now;
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= CNT_W'(scan_idx + 1'b1);
    end
    if (match) begin
      hit_idx <= pend_idx;
    end
    if (state == ST_HIT) begin
      expired <= (elapsed > TIME_W'(cfg.window_seconds));
    end
    if (state == ST_UPDATE || state == ST_MISS) begin
      res <= res_next;
    end
  end

endmodule
